FILE: rtl/assert_macros.svh
// Assertion macros used by the encoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// The property must hold at every rising clock edge outside reset.
`define BAE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// When the antecedent holds, the consequent must hold in the next cycle.
`define BAE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/baenc_pkg.sv
// Types, constants and defaults shared by the binary arithmetic encoder.
package baenc_pkg;

	localparam int CTX_W = 13;
	localparam int RATE_W = 4;
	localparam int WORD_W = 32;
	localparam int IV_W = 64;
	localparam int RENORM_W = 16;
	localparam logic [IV_W-1:0] RANGE_INIT = 64'h0000_FFFF_FFFF_FFFF;

	localparam int PROB_ENTRIES_DEF = 8192;
	localparam int USE_BITS_DEF = 10;
	localparam int STORE_BITS_DEF = 24;
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic {
		OP_CODE = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef struct packed {
		op_t opcode;
		logic [CTX_W-1:0] context_index;
		logic bit_value;
		logic [RATE_W-1:0] rate_shift;
	} cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0] out_word;
		logic last_word;
	} word_t;

	typedef struct packed {
		logic [1:0] count;
		word_t w0;
		word_t w1;
	} push_t;

	typedef struct packed {
		logic s0_valid;
		logic s1_valid;
		logic s2_valid;
		logic s1_flush;
		logic clearing;
	} core_status_t;

endpackage

FILE: rtl/adaptive_binary_arithmetic_encoder.sv
// Top level of the adaptive binary arithmetic encoder.
// The cmd channel takes one request per accepted valid/stall handshake: a code
// request encodes one bit under an adaptive probability picked by its context,
// a flush request emits the 64-bit low as two words and restarts the interval.
// The code channel delivers 32-bit stream words in order; last_word marks the
// final word a request causes. A code request gives one word when the range
// must renormalize and none otherwise, a flush always gives two.
// No request is accepted while another sits in the first stage, as the low/range
// loop needs: one stage renormalizes and multiplies the range by the probability,
// the next updates low, range and the probability entry, which is written back to
// the probability memory with forwarding to the next request.
// A request's words are formed in stage s1 and reach the code channel through the output queue.
// After reset, cmd_stall stays high while the probability memory (PROB_ENTRIES
// entries, 8192 by default) is cleared one entry per cycle.
// When the receiver stalls, words wait in a small queue and cmd_stall rises
// once the queue cannot take the words of another request.
`include "assert_macros.svh"

module adaptive_binary_arithmetic_encoder #(
	parameter int PROB_ENTRIES = baenc_pkg::PROB_ENTRIES_DEF,
	parameter int USE_BITS = baenc_pkg::USE_BITS_DEF,
	parameter int STORE_BITS = baenc_pkg::STORE_BITS_DEF,
	parameter int QUEUE_DEPTH = baenc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  baenc_pkg::cmd_t cmd,
	output logic code_valid,
	input  logic code_stall,
	output baenc_pkg::word_t code
);

	import baenc_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	push_t push;
	core_status_t st;
	logic [CNT_W-1:0] level;
	logic [CNT_W:0] need;
	logic room;
	logic take;

	baenc_core #(
		.PROB_ENTRIES(PROB_ENTRIES),
		.USE_BITS(USE_BITS),
		.STORE_BITS(STORE_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.cmd(cmd),
		.push(push),
		.status(st)
	);

	baenc_outq #(
		.DEPTH(QUEUE_DEPTH)
	) u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.valid(code_valid),
		.stall(code_stall),
		.head(code),
		.level(level)
	);

	always_comb begin
		need = (CNT_W+1)'(level) + (CNT_W+1)'(push.count) + (CNT_W+1)'(2);
		room = (need <= (CNT_W+1)'(QUEUE_DEPTH));
		cmd_stall = st.s0_valid || st.clearing || !room;
		take = cmd_valid && !cmd_stall;
	end

	`BAE_ASSERT(a_stage_gap, clk, arst_n, !(st.s1_valid && st.s2_valid), "Two requests overlap in the interval loop")
	`BAE_ASSERT(a_queue_bound, clk, arst_n, level <= CNT_W'(QUEUE_DEPTH), "Output queue overflow")
	`BAE_ASSERT(a_flush_pair, clk, arst_n, !code_valid || code.last_word || level >= CNT_W'(2), "Flush word without its partner")
	`BAE_ASSERT_NEXT(a_flush_out, clk, arst_n, st.s1_flush, code_valid, "Flush produced no output word")

endmodule

FILE: rtl/baenc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module baenc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/baenc_core.sv
// Probability memory read-modify-write and interval update pipeline.
module baenc_core #(
	parameter int PROB_ENTRIES = baenc_pkg::PROB_ENTRIES_DEF,
	parameter int USE_BITS = baenc_pkg::USE_BITS_DEF,
	parameter int STORE_BITS = baenc_pkg::STORE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  baenc_pkg::cmd_t cmd,
	output baenc_pkg::push_t push,
	output baenc_pkg::core_status_t status
);

	import baenc_pkg::*;

	localparam int IDX_W = $clog2(PROB_ENTRIES);
	localparam int SHL = (USE_BITS > STORE_BITS) ? USE_BITS - STORE_BITS : 0;
	localparam int SHR = (STORE_BITS > USE_BITS) ? STORE_BITS - USE_BITS : 0;
	localparam int QX_W = ((USE_BITS > STORE_BITS) ? USE_BITS : STORE_BITS) + 2;
	localparam int Q_HALF = 1 << (USE_BITS - 1);
	localparam int P_W = IV_W + USE_BITS;
	localparam int R2_W = IV_W - USE_BITS;
	localparam int D_W = STORE_BITS + 2;
	localparam longint TGT_MAG = longint'(1) << (STORE_BITS - 1);

	function automatic logic [IDX_W-1:0] wrap_ctx(input logic [CTX_W-1:0] x);
		logic [CTX_W-1:0] r;
		r = x;
		for (int j = CTX_W - 1; j >= 0; j--) begin
			if ((longint'(PROB_ENTRIES) << j) <= longint'(r)) begin
				r = r - CTX_W'(PROB_ENTRIES << j);
			end
		end
		return IDX_W'(r);
	endfunction

	logic valid_s0, valid_s1, valid_s2;
	op_t op_s0, op_s1, op_s2;
	logic [IDX_W-1:0] idx_s0, idx_s1, idx_s2;
	logic bit_s0, bit_s1, bit_s2;
	logic [RATE_W-1:0] rate_s0, rate_s1, rate_s2;

	logic [IV_W-1:0] low_q, range_q;
	logic [IV_W-1:0] low_s2, rng_s2;
	logic [R2_W-1:0] r2_s2;
	logic signed [STORE_BITS-1:0] entry_s2;

	logic clr_active_q;
	logic [IDX_W-1:0] clr_addr_q;
	logic fwd_valid_q;
	logic [IDX_W-1:0] fwd_idx_q;
	logic [STORE_BITS-1:0] fwd_data_q;

	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [STORE_BITS-1:0] ram_wdata, ram_rdata;

	logic signed [STORE_BITS-1:0] entry_s1;
	logic renorm_s1, clamp_s1;
	logic [IV_W-1:0] low_n, rng_n;
	logic signed [QX_W-1:0] qx;
	logic [QX_W-1:0] qsum;
	logic [USE_BITS-1:0] q_s1;
	logic [P_W-1:0] prod;

	logic [IV_W-1:0] r2x, low_nx, range_nx;
	logic [RATE_W-1:0] lr;
	logic signed [D_W-1:0] tgt, diff, entry_sum;
	logic [STORE_BITS-1:0] entry_nx;
	logic code_wr;

	baenc_ram #(
		.WIDTH(STORE_BITS),
		.DEPTH(PROB_ENTRIES)
	) u_prob_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_s0),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (fwd_valid_q && (fwd_idx_q == idx_s1)) begin
			entry_s1 = signed'(fwd_data_q);
		end else begin
			entry_s1 = signed'(ram_rdata);
		end

		renorm_s1 = (range_q[IV_W-1:RENORM_W] == '0);
		clamp_s1 = (range_q[WORD_W-1:0] > ~low_q[WORD_W-1:0]);
		if (renorm_s1) begin
			low_n = {low_q[WORD_W-1:0], {WORD_W{1'b0}}};
			if (clamp_s1) begin
				rng_n = {~low_q[WORD_W-1:0], {WORD_W{1'b1}}};
			end else begin
				rng_n = {range_q[WORD_W-1:0], {WORD_W{1'b1}}};
			end
		end else begin
			low_n = low_q;
			rng_n = range_q;
		end

		qx = (QX_W'(entry_s1) <<< SHL) >>> SHR;
		qsum = qx + QX_W'(entry_s1[STORE_BITS-1]) + QX_W'(Q_HALF);
		q_s1 = qsum[USE_BITS-1:0];
		prod = P_W'(rng_n) * P_W'(q_s1);

		push = '0;
		if (valid_s1) begin
			if (op_s1 == OP_FLUSH) begin
				push.count = 2'd2;
				push.w0.out_word = low_q[IV_W-1:WORD_W];
				push.w0.last_word = 1'b0;
				push.w1.out_word = low_q[WORD_W-1:0];
				push.w1.last_word = 1'b1;
			end else if (renorm_s1) begin
				push.count = 2'd1;
				push.w0.out_word = low_q[IV_W-1:WORD_W];
				push.w0.last_word = 1'b1;
			end
		end
	end

	always_comb begin
		r2x = IV_W'(r2_s2);
		if (op_s2 == OP_FLUSH) begin
			low_nx = '0;
			range_nx = RANGE_INIT;
		end else if (bit_s2) begin
			low_nx = low_s2 + r2x;
			range_nx = rng_s2 - r2x;
		end else begin
			low_nx = low_s2;
			range_nx = r2x - IV_W'(1);
		end

		lr = (rate_s2 == '0) ? RATE_W'(1) : rate_s2;
		tgt = bit_s2 ? D_W'(-TGT_MAG) : D_W'(TGT_MAG);
		diff = tgt - D_W'(entry_s2);
		entry_sum = D_W'(entry_s2) + (diff >>> lr);
		entry_nx = entry_sum[STORE_BITS-1:0];

		code_wr = valid_s2 && (op_s2 == OP_CODE);
		ram_we = clr_active_q || code_wr;
		ram_waddr = clr_active_q ? clr_addr_q : idx_s2;
		ram_wdata = clr_active_q ? '0 : entry_nx;

		status.s0_valid = valid_s0;
		status.s1_valid = valid_s1;
		status.s2_valid = valid_s2;
		status.s1_flush = valid_s1 && (op_s1 == OP_FLUSH);
		status.clearing = clr_active_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			low_q <= '0;
			range_q <= RANGE_INIT;
			clr_active_q <= 1'b1;
			clr_addr_q <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			valid_s0 <= take;
			valid_s1 <= valid_s0;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				low_q <= low_nx;
				range_q <= range_nx;
			end
			if (clr_active_q) begin
				if (clr_addr_q == IDX_W'(PROB_ENTRIES - 1)) begin
					clr_active_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + IDX_W'(1);
				end
			end
			if (code_wr) begin
				fwd_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s0 <= cmd.opcode;
			idx_s0 <= wrap_ctx(cmd.context_index);
			bit_s0 <= cmd.bit_value;
			rate_s0 <= cmd.rate_shift;
		end
		op_s1 <= op_s0;
		idx_s1 <= idx_s0;
		bit_s1 <= bit_s0;
		rate_s1 <= rate_s0;
		op_s2 <= op_s1;
		idx_s2 <= idx_s1;
		bit_s2 <= bit_s1;
		rate_s2 <= rate_s1;
		low_s2 <= low_n;
		rng_s2 <= rng_n;
		r2_s2 <= prod[IV_W-1:USE_BITS];
		entry_s2 <= entry_s1;
		if (code_wr) begin
			fwd_idx_q <= idx_s2;
			fwd_data_q <= entry_nx;
		end
	end

endmodule

FILE: rtl/baenc_outq.sv
// Output word queue that takes up to two words per cycle and hands out one per cycle while not stalled.
module baenc_outq #(
	parameter int DEPTH = baenc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  baenc_pkg::push_t push,
	output logic valid,
	input  logic stall,
	output baenc_pkg::word_t head,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	import baenc_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	word_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] level_q;
	logic pop;

	assign valid = (level_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign level = level_q;
	assign pop = valid && !stall;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.w0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push.w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			level_q <= level_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

endmodule
